// ===== sv/tqs_pkg.sv =====
package tqs_pkg;

  localparam int SMP_W         = 12;
  localparam int DEB_W         = 16;
  localparam int TIME_W        = 32;
  localparam int COORD_W       = 16;
  localparam int DIV_W         = 2 * SMP_W;
  localparam int FIELD_SAMPLES = 5;
  localparam int SAMPLES_DEF   = 5;
  localparam int APB_ADDR_W    = 5;
  localparam int APB_DATA_W    = 32;

  localparam logic [COORD_W-1:0] NOT_TOUCHED_RAW = 16'hFFFF;
  localparam logic [COORD_W-1:0] SAT16           = 16'hFFFF;

  typedef enum logic [2:0] {
    REG_X_START  = 3'd0,
    REG_X_END    = 3'd1,
    REG_Y_START  = 3'd2,
    REG_Y_END    = 3'd3,
    REG_X_PIX    = 3'd4,
    REG_Y_PIX    = 3'd5,
    REG_PRESSURE = 3'd6,
    REG_DEBOUNCE = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [SMP_W-1:0] x_raw_start;
    logic [SMP_W-1:0] x_raw_end;
    logic [SMP_W-1:0] y_raw_start;
    logic [SMP_W-1:0] y_raw_end;
    logic [SMP_W-1:0] x_pixels;
    logic [SMP_W-1:0] y_pixels;
    logic [SMP_W-1:0] pressure_limit;
    logic [DEB_W-1:0] debounce_ms;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_AVG,
    ST_MULT,
    ST_SCALE_GO,
    ST_SCALE_WAIT,
    ST_OUT
  } state_e;

endpackage

// ===== sv/tqs_cfg_regs.sv =====
module tqs_cfg_regs import tqs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_X_START:  cfg_d.x_raw_start    = pwdata[SMP_W-1:0];
        REG_X_END:    cfg_d.x_raw_end      = pwdata[SMP_W-1:0];
        REG_Y_START:  cfg_d.y_raw_start    = pwdata[SMP_W-1:0];
        REG_Y_END:    cfg_d.y_raw_end      = pwdata[SMP_W-1:0];
        REG_X_PIX:    cfg_d.x_pixels       = pwdata[SMP_W-1:0];
        REG_Y_PIX:    cfg_d.y_pixels       = pwdata[SMP_W-1:0];
        REG_PRESSURE: cfg_d.pressure_limit = pwdata[SMP_W-1:0];
        REG_DEBOUNCE: cfg_d.debounce_ms    = pwdata[DEB_W-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_X_START:  prdata = APB_DATA_W'(cfg_q.x_raw_start);
      REG_X_END:    prdata = APB_DATA_W'(cfg_q.x_raw_end);
      REG_Y_START:  prdata = APB_DATA_W'(cfg_q.y_raw_start);
      REG_Y_END:    prdata = APB_DATA_W'(cfg_q.y_raw_end);
      REG_X_PIX:    prdata = APB_DATA_W'(cfg_q.x_pixels);
      REG_Y_PIX:    prdata = APB_DATA_W'(cfg_q.y_pixels);
      REG_PRESSURE: prdata = APB_DATA_W'(cfg_q.pressure_limit);
      REG_DEBOUNCE: prdata = APB_DATA_W'(cfg_q.debounce_ms);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_raw_start    <= 12'd0;
      cfg_q.x_raw_end      <= 12'd4095;
      cfg_q.y_raw_start    <= 12'd0;
      cfg_q.y_raw_end      <= 12'd4095;
      cfg_q.x_pixels       <= 12'd320;
      cfg_q.y_pixels       <= 12'd240;
      cfg_q.pressure_limit <= 12'd1500;
      cfg_q.debounce_ms    <= 16'd50;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== sv/tqs_serial_div.sv =====
module tqs_serial_div import tqs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [SMP_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [SMP_W-1:0] rem_q, rem_d;
  logic [SMP_W-1:0] dsr_q, dsr_d;
  logic [SMP_W:0]   trial;
  logic             fits;

  // restoring divide, one quotient bit per cycle, MSB first
  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DIV_W - 1);
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? SMP_W'(trial - {1'b0, dsr_q}) : trial[SMP_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== sv/touch_qualify_and_scale_core.sv =====
// Flow: an input transfer with the touch not latched goes straight to the result state; a
// latched touch sums SAMPLES_PER_READ samples, averages them and multiplies, then skips
// scaling or runs the serial divide for the scaling step before the result is loaded.
// Throughput: one query at a time; the next input transfer is taken once the result is
// loaded, and a stalled result only blocks once a second result waits.
// Reset (rst_ni low, async): registers to defaults, touch released.
module touch_qualify_and_scale_core import tqs_pkg::*; #(
  parameter int SAMPLES_PER_READ = SAMPLES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  func_i,
  input  logic                  pen_detected_i,
  input  logic [SMP_W-1:0]      z1_sample_i,
  input  logic [SMP_W-1:0]      z2_sample_i,
  input  logic [TIME_W-1:0]     now_ms_i,
  input  logic [SMP_W-1:0]      sample_a_i,
  input  logic [SMP_W-1:0]      sample_b_i,
  input  logic [SMP_W-1:0]      sample_c_i,
  input  logic [SMP_W-1:0]      sample_d_i,
  input  logic [SMP_W-1:0]      sample_e_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  touched_o,
  output logic [COORD_W-1:0]    raw_average_o,
  output logic [COORD_W-1:0]    pixel_coord_o
);

  localparam int SUM_W   = SMP_W + $clog2(SAMPLES_PER_READ);
  localparam int CNT_W   = $clog2(SAMPLES_PER_READ + 1);
  localparam int FLD_W   = $clog2(FIELD_SAMPLES);
  // average by reciprocal multiply; the extra shift keeps it exact over the sum range
  localparam int RCP_SH  = SUM_W + 5;
  localparam int RCP_W   = RCP_SH + 1;
  localparam int RPROD_W = SUM_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP_MUL =
    RCP_W'(((64'd1 << RCP_SH) + SAMPLES_PER_READ - 1) / SAMPLES_PER_READ);

  cfg_t cfg;

  tqs_cfg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  state_e state_q, state_d;

  logic              latched_q, latched_d;
  logic [TIME_W-1:0] deb_start_q, deb_start_d;
  logic              out_valid_q, out_valid_d;
  logic              out_load;

  logic [SMP_W-1:0]  smp_q [FIELD_SAMPLES];
  logic              axis_q;
  logic [SUM_W-1:0]  sum_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [FLD_W-1:0]  fld_q;
  logic [SMP_W-1:0]  avg_q;
  logic [DIV_W-1:0]  prod_q;
  logic              res_touched_q;
  logic [COORD_W-1:0] res_avg_q, res_pix_q;
  logic              touched_q;
  logic [COORD_W-1:0] raw_avg_q, pix_q;

  logic              in_xfer;
  logic [SMP_W-1:0]  zdiff;
  logic              current;
  logic [TIME_W-1:0] elapsed;
  logic [SMP_W-1:0]  cal_start, cal_end, cal_pix, span;
  logic [RPROD_W-1:0] avg_prod;
  logic [SMP_W-1:0]  avg_w;
  logic              skip_scale;
  logic              last_sample;

  logic              div_start, div_done;
  logic [DIV_W-1:0]  div_quot;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;

  // debounce
  assign zdiff   = (z2_sample_i > z1_sample_i) ? (z2_sample_i - z1_sample_i)
                                               : (z1_sample_i - z2_sample_i);
  assign current = pen_detected_i && (zdiff <= cfg.pressure_limit);
  assign elapsed = now_ms_i - deb_start_q;

  always_comb begin
    latched_d   = latched_q;
    deb_start_d = deb_start_q;
    if (in_xfer) begin
      if (!latched_q && current) begin
        latched_d = (elapsed >= TIME_W'(cfg.debounce_ms));
      end else if (latched_q && !current) begin
        latched_d = 1'b0;
      end else begin
        deb_start_d = now_ms_i;
      end
    end
  end

  assign cal_start = axis_q ? cfg.y_raw_start : cfg.x_raw_start;
  assign cal_end   = axis_q ? cfg.y_raw_end   : cfg.x_raw_end;
  assign cal_pix   = axis_q ? cfg.y_pixels    : cfg.x_pixels;
  assign span      = cal_end - cal_start;

  assign avg_prod    = {{RCP_W{1'b0}}, sum_q} * {{SUM_W{1'b0}}, RCP_MUL};
  assign avg_w       = avg_prod[RCP_SH +: SMP_W];
  assign skip_scale  = (cal_end <= cal_start) || (avg_q < cal_start);
  assign last_sample = (cnt_q == CNT_W'(SAMPLES_PER_READ - 1));

  assign div_start = (state_q == ST_SCALE_GO);

  tqs_serial_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (span),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) state_d = latched_d ? ST_ACCUM : ST_OUT;
      end
      ST_ACCUM: begin
        if (last_sample) state_d = ST_AVG;
      end
      ST_AVG: begin
        state_d = ST_MULT;
      end
      ST_MULT: begin
        state_d = skip_scale ? ST_OUT : ST_SCALE_GO;
      end
      ST_SCALE_GO: begin
        state_d = ST_SCALE_WAIT;
      end
      ST_SCALE_WAIT: begin
        if (div_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      latched_q   <= 1'b0;
      deb_start_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      latched_q   <= latched_d;
      deb_start_q <= deb_start_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          smp_q[0]      <= sample_a_i;
          smp_q[1]      <= sample_b_i;
          smp_q[2]      <= sample_c_i;
          smp_q[3]      <= sample_d_i;
          smp_q[4]      <= sample_e_i;
          axis_q        <= func_i;
          sum_q         <= '0;
          cnt_q         <= '0;
          fld_q         <= '0;
          res_touched_q <= latched_d;
          res_avg_q     <= NOT_TOUCHED_RAW;
          res_pix_q     <= '0;
        end
      end
      ST_ACCUM: begin
        sum_q <= sum_q + SUM_W'(smp_q[fld_q]);
        cnt_q <= cnt_q + 1'b1;
        fld_q <= (fld_q == FLD_W'(FIELD_SAMPLES - 1)) ? '0 : fld_q + 1'b1;
      end
      ST_AVG: begin
        avg_q     <= avg_w;
        res_avg_q <= COORD_W'(avg_w);
      end
      ST_MULT: begin
        prod_q <= {{SMP_W{1'b0}}, avg_q - cal_start} * {{SMP_W{1'b0}}, cal_pix};
      end
      ST_SCALE_WAIT: begin
        if (div_done) begin
          res_pix_q <= (|div_quot[DIV_W-1:COORD_W]) ? SAT16 : div_quot[COORD_W-1:0];
        end
      end
      ST_OUT: begin
        if (out_load) begin
          touched_q <= res_touched_q;
          raw_avg_q <= res_avg_q;
          pix_q     <= res_pix_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign touched_o     = touched_q;
  assign raw_average_o = raw_avg_q;
  assign pixel_coord_o = pix_q;

endmodule

// ===== sv/tqs_checker.sv =====
module tqs_checker import tqs_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               pready,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               touched_o,
  input logic [COORD_W-1:0] raw_average_o,
  input logic [COORD_W-1:0] pixel_coord_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(touched_o) &&
      $stable(raw_average_o) && $stable(pixel_coord_o))
    else $error("result changed while stalled");

  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after an input transfer");

  a_untouched_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !touched_o |-> raw_average_o == NOT_TOUCHED_RAW && pixel_coord_o == '0)
    else $error("untouched result carries data");

  a_touched_avg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && touched_o |-> raw_average_o <= COORD_W'(4095))
    else $error("average out of sample range");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind touch_qualify_and_scale_core tqs_checker u_tqs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .pready        (pready),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .touched_o     (touched_o),
  .raw_average_o (raw_average_o),
  .pixel_coord_o (pixel_coord_o)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import tqs_pkg::*;

  localparam logic AXIS_X = 1'b0;
  localparam logic AXIS_Y = 1'b1;

  localparam int NUM_PHASES    = 10;
  localparam int PHASE_ITEMS   = 124;
  localparam int HOLD_AT       = 450;   // queries sent before the long output hold-off
  localparam int HOLD_CYCLES   = 500;
  localparam int QUIET_LIMIT   = 4000;
  localparam int DRAIN_CYCLES  = 80;

  typedef struct packed {
    logic                                func;
    logic                                pen;
    logic [SMP_W-1:0]                    z1;
    logic [SMP_W-1:0]                    z2;
    logic [TIME_W-1:0]                   now;
    logic [FIELD_SAMPLES-1:0][SMP_W-1:0] smp;
  } touch_query_t;

  typedef struct packed {
    logic               touched;
    logic [COORD_W-1:0] raw_average;
    logic [COORD_W-1:0] pixel_coord;
  } touch_report_t;

  class touch_scoreboard;
    cfg_t              cfg;
    logic              latched;
    logic [TIME_W-1:0] settle_start_ms;
    touch_report_t     pending_reports[$];
    int                failures;

    function new();
      cfg.x_raw_start    = 12'd0;
      cfg.x_raw_end      = 12'd4095;
      cfg.y_raw_start    = 12'd0;
      cfg.y_raw_end      = 12'd4095;
      cfg.x_pixels       = 12'd320;
      cfg.y_pixels       = 12'd240;
      cfg.pressure_limit = 12'd1500;
      cfg.debounce_ms    = 16'd50;
      latched            = 1'b0;
      settle_start_ms    = '0;
      failures           = 0;
    endfunction

    function void set_register(reg_idx_e idx, logic [APB_DATA_W-1:0] value);
      case (idx)
        REG_X_START:  cfg.x_raw_start    = value[SMP_W-1:0];
        REG_X_END:    cfg.x_raw_end      = value[SMP_W-1:0];
        REG_Y_START:  cfg.y_raw_start    = value[SMP_W-1:0];
        REG_Y_END:    cfg.y_raw_end      = value[SMP_W-1:0];
        REG_X_PIX:    cfg.x_pixels       = value[SMP_W-1:0];
        REG_Y_PIX:    cfg.y_pixels       = value[SMP_W-1:0];
        REG_PRESSURE: cfg.pressure_limit = value[SMP_W-1:0];
        REG_DEBOUNCE: cfg.debounce_ms    = value[DEB_W-1:0];
        default: ;
      endcase
    endfunction

    // Qualify, debounce, average and scale one accepted query.
    function void note_query(touch_query_t q);
      logic [SMP_W-1:0]  diff;
      logic [TIME_W-1:0] elapsed;
      logic              pressed;
      int unsigned       sum, avg, lo, hi, px, quot;
      int                i;
      touch_report_t     r;
      diff    = (q.z2 > q.z1) ? q.z2 - q.z1 : q.z1 - q.z2;
      pressed = q.pen && (diff <= cfg.pressure_limit);
      elapsed = q.now - settle_start_ms;
      if (!latched && pressed) begin
        if (elapsed >= TIME_W'(cfg.debounce_ms)) latched = 1'b1;
      end else if (latched && !pressed) begin
        latched = 1'b0;
      end else begin
        settle_start_ms = q.now;
      end
      r.touched     = latched;
      r.raw_average = NOT_TOUCHED_RAW;
      r.pixel_coord = '0;
      if (latched) begin
        sum = 0;
        for (i = 0; i < SAMPLES_DEF; i++) sum += 32'(q.smp[i % FIELD_SAMPLES]);
        avg = sum / SAMPLES_DEF;
        if (q.func == AXIS_X) begin
          lo = 32'(cfg.x_raw_start);
          hi = 32'(cfg.x_raw_end);
          px = 32'(cfg.x_pixels);
        end else begin
          lo = 32'(cfg.y_raw_start);
          hi = 32'(cfg.y_raw_end);
          px = 32'(cfg.y_pixels);
        end
        quot = (hi <= lo || avg < lo) ? 0 : ((avg - lo) * px) / (hi - lo);
        r.raw_average = COORD_W'(avg);
        r.pixel_coord = (quot > 65535) ? SAT16 : COORD_W'(quot);
      end
      pending_reports.push_back(r);
    endfunction

    function void check_report(logic touched, logic [COORD_W-1:0] raw_average,
                               logic [COORD_W-1:0] pixel_coord);
      touch_report_t want;
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result transfer: touched %0b avg %0d pixel %0d",
                 $time, touched, raw_average, pixel_coord);
        failures++;
        return;
      end
      want = pending_reports.pop_front();
      if (touched !== want.touched) begin
        $display("%0t: touched expected %0b, got %0b", $time, want.touched, touched);
        failures++;
      end
      if (raw_average !== want.raw_average) begin
        $display("%0t: raw_average expected %0d, got %0d", $time, want.raw_average,
                 raw_average);
        failures++;
      end
      if (pixel_coord !== want.pixel_coord) begin
        $display("%0t: pixel_coord expected %0d, got %0d", $time, want.pixel_coord,
                 pixel_coord);
        failures++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic                  func_i = 1'b0;
  logic                  pen_detected_i = 1'b0;
  logic [SMP_W-1:0]      z1_sample_i = '0;
  logic [SMP_W-1:0]      z2_sample_i = '0;
  logic [TIME_W-1:0]     now_ms_i = '0;
  logic [SMP_W-1:0]      sample_a_i = '0;
  logic [SMP_W-1:0]      sample_b_i = '0;
  logic [SMP_W-1:0]      sample_c_i = '0;
  logic [SMP_W-1:0]      sample_d_i = '0;
  logic [SMP_W-1:0]      sample_e_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic                  touched_o;
  logic [COORD_W-1:0]    raw_average_o;
  logic [COORD_W-1:0]    pixel_coord_o;

  touch_scoreboard sb;
  int              queries_sent = 0;
  int              quiet_cycles = 0;
  int              ready_wait = 0;
  int              ready_run = 0;
  logic            hold_done = 1'b0;

  touch_qualify_and_scale_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .pen_detected_i (pen_detected_i),
    .z1_sample_i    (z1_sample_i),
    .z2_sample_i    (z2_sample_i),
    .now_ms_i       (now_ms_i),
    .sample_a_i     (sample_a_i),
    .sample_b_i     (sample_b_i),
    .sample_c_i     (sample_c_i),
    .sample_d_i     (sample_d_i),
    .sample_e_i     (sample_e_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .touched_o      (touched_o),
    .raw_average_o  (raw_average_o),
    .pixel_coord_o  (pixel_coord_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Result side: check each transfer, then pick the next ready pattern.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_report(touched_o, raw_average_o, pixel_coord_o);
    end
    if (!hold_done && queries_sent >= HOLD_AT) begin
      hold_done   <= 1'b1;
      ready_wait  <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (ready_wait != 0) begin
      ready_wait  <= ready_wait - 1;
      out_ready_i <= 1'b0;
    end else if (ready_run != 0) begin
      ready_run   <= ready_run - 1;
      out_ready_i <= 1'b1;
    end else begin
      ready_run <= ($urandom_range(0, 19) == 0) ? 300 : $urandom_range(0, 30);
      case ($urandom_range(0, 9))
        0:       ready_wait <= $urandom_range(20, 60);
        1, 2:    ready_wait <= 0;
        default: ready_wait <= $urandom_range(1, 3);
      endcase
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic touch_query_t make_query(logic func, logic pen,
                                              logic [SMP_W-1:0] z1, logic [SMP_W-1:0] z2,
                                              logic [TIME_W-1:0] now,
                                              logic [SMP_W-1:0] a, logic [SMP_W-1:0] b,
                                              logic [SMP_W-1:0] c, logic [SMP_W-1:0] d,
                                              logic [SMP_W-1:0] e);
    touch_query_t q;
    q.func   = func;
    q.pen    = pen;
    q.z1     = z1;
    q.z2     = z2;
    q.now    = now;
    q.smp[0] = a;
    q.smp[1] = b;
    q.smp[2] = c;
    q.smp[3] = d;
    q.smp[4] = e;
    return q;
  endfunction

  // Called at a rising edge; leaves valid high after the transfer.
  task automatic send_query(input touch_query_t q);
    func_i         <= q.func;
    pen_detected_i <= q.pen;
    z1_sample_i    <= q.z1;
    z2_sample_i    <= q.z2;
    now_ms_i       <= q.now;
    sample_a_i     <= q.smp[0];
    sample_b_i     <= q.smp[1];
    sample_c_i     <= q.smp[2];
    sample_d_i     <= q.smp[3];
    sample_e_i     <= q.smp[4];
    in_valid_i     <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_query(q);
    queries_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_reports.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_register(input reg_idx_e idx, input logic [APB_DATA_W-1:0] value);
    logic [APB_DATA_W-1:0] data;
    // bits above the register width are junk that the block must drop
    data = $urandom_range(0, 1) ? $urandom : '0;
    if (idx == REG_DEBOUNCE) data[DEB_W-1:0] = value[DEB_W-1:0];
    else data[SMP_W-1:0] = value[SMP_W-1:0];
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.set_register(idx, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_settings(input int xs, input int xe, input int ys, input int ye,
                                input int xp, input int yp, input int lim, input int deb);
    drain();
    write_register(REG_X_START, xs);
    write_register(REG_X_END, xe);
    write_register(REG_Y_START, ys);
    write_register(REG_Y_END, ye);
    write_register(REG_X_PIX, xp);
    write_register(REG_Y_PIX, yp);
    write_register(REG_PRESSURE, lim);
    write_register(REG_DEBOUNCE, deb);
  endtask

  initial begin : stimulus
    touch_query_t      q;
    logic [TIME_W-1:0] clock_ms;
    int                phase, n, k, gap, pick, spread, lim, stroke_left;
    int                xs, xe, ys, ye, xp, yp, deb, center, v, swap_z;
    logic              burst, cluster;

    sb          = new();
    clock_ms    = '0;
    stroke_left = 0;
    burst       = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset calibration: debounce 50 ms, pressure limit 1500
    send_query(make_query(AXIS_X, 1'b0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_query(make_query(AXIS_Y, 1'b1, 0, 1500, 10, 4095, 4095, 4095, 4095, 4095));
    send_query(make_query(AXIS_X, 1'b1, 4095, 2594, 20, 1, 2, 3, 4, 5));
    send_query(make_query(AXIS_X, 1'b1, 2000, 2000, 69, 7, 7, 7, 7, 7));
    send_query(make_query(AXIS_X, 1'b1, 2000, 2000, 70, 4095, 4095, 4095, 4095, 4095));
    send_query(make_query(AXIS_Y, 1'b1, 0, 0, 71, 0, 0, 0, 0, 0));
    send_query(make_query(AXIS_Y, 1'b1, 4095, 4095, 72, 4095, 0, 4095, 0, 4095));
    send_query(make_query(AXIS_X, 1'b0, 4095, 4095, 73, 9, 9, 9, 9, 9));

    // one-count x span saturates, y span empty, zero limit, no debounce
    apply_settings(100, 101, 3000, 3000, 4095, 4095, 0, 0);
    send_query(make_query(AXIS_X, 1'b1, 12'hABC, 12'hABC, 32'h1234_5678,
                          200, 200, 200, 200, 200));
    send_query(make_query(AXIS_X, 1'b1, 12'h543, 12'h543, 32'h1234_5679, 50, 50, 50, 50, 50));
    send_query(make_query(AXIS_Y, 1'b1, 0, 0, 32'h1234_567A, 3500, 3500, 3500, 3500, 3500));
    send_query(make_query(AXIS_X, 1'b1, 1, 0, 32'h1234_567B, 1, 2, 3, 4, 5));

    // longest debounce across the time stamp wrap
    apply_settings(0, 4095, 0, 4095, 4095, 0, 4095, 65535);
    send_query(make_query(AXIS_X, 1'b0, 0, 0, 32'hFFFF_FFF0, 0, 0, 0, 0, 0));
    send_query(make_query(AXIS_X, 1'b1, 0, 4095, 32'h0000_FFEE, 4095, 4095, 4095, 4095, 4095));
    send_query(make_query(AXIS_X, 1'b1, 4095, 0, 32'h0000_FFEF, 4095, 4095, 4095, 4095, 4094));
    send_query(make_query(AXIS_Y, 1'b1, 4095, 4095, 32'hFFFF_FFFF, 3000, 12, 77, 4000, 2048));
    send_query(make_query(AXIS_X, 1'b1, 4095, 4095, 32'h0000_0000, 0, 0, 0, 0, 0));

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: apply_settings(0, 4095, 0, 4095, 320, 240, 1500, 50);
        1: apply_settings(4095, 4095, 4095, 4095, 4095, 4095, 4095, 65535);
        2: apply_settings(0, 0, 0, 0, 0, 0, 0, 0);
        3: apply_settings(0, 4095, 4094, 4095, 4095, 4095, 4095, 0);
        default: begin
          xs = $urandom_range(0, 4095);
          ys = $urandom_range(0, 4095);
          xe = xs + $urandom_range(1, 3000);
          ye = ys + $urandom_range(1, 3000);
          if (xe > 4095 || $urandom_range(0, 3) == 0) xe = $urandom_range(0, 4095);
          if (ye > 4095 || $urandom_range(0, 3) == 0) ye = $urandom_range(0, 4095);
          xp = $urandom_range(0, 4095);
          yp = $urandom_range(0, 4095);
          case ($urandom_range(0, 3))
            0:       lim = 0;
            1:       lim = 4095;
            default: lim = $urandom_range(0, 4095);
          endcase
          case ($urandom_range(0, 3))
            0:       deb = 0;
            1:       deb = $urandom_range(1, 200);
            2:       deb = $urandom_range(0, 65535);
            default: deb = 65535;
          endcase
          apply_settings(xs, xe, ys, ye, xp, yp, lim, deb);
        end
      endcase

      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 64 == 0) burst = ($urandom_range(0, 2) == 0);
        if (!burst) begin
          gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
          if (gap != 0) begin
            in_valid_i <= 1'b0;
            repeat (gap) @(posedge clk_i);
          end
        end

        // mostly strokes of qualified touches with advancing time, some noise
        clock_ms += $urandom_range(0, sb.cfg.debounce_ms / 3 + 4);
        if ($urandom_range(0, 99) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 2000);
        lim    = 32'(sb.cfg.pressure_limit);
        q.func = 1'($urandom_range(0, 1));
        pick   = $urandom_range(0, 99);
        if (pick < 8) begin
          q.pen    = 1'($urandom_range(0, 1));
          spread   = -1;
          clock_ms = $urandom;
        end else if (stroke_left > 0) begin
          stroke_left--;
          q.pen  = 1'b1;
          spread = $urandom_range(0, lim);
        end else begin
          if ($urandom_range(0, 2) == 0) stroke_left = $urandom_range(1, 40);
          if (lim == 4095 || $urandom_range(0, 1) == 1) begin
            q.pen  = 1'b0;
            spread = -1;
          end else begin
            q.pen  = 1'b1;
            spread = $urandom_range(lim + 1, 4095);
          end
        end
        if (spread < 0) begin
          q.z1 = SMP_W'($urandom_range(0, 4095));
          q.z2 = SMP_W'($urandom_range(0, 4095));
        end else begin
          v      = $urandom_range(0, 4095 - spread);
          swap_z = $urandom_range(0, 1);
          q.z1   = SMP_W'(swap_z ? v + spread : v);
          q.z2   = SMP_W'(swap_z ? v : v + spread);
        end
        q.now   = clock_ms;
        center  = $urandom_range(0, 4095);
        cluster = 1'($urandom_range(0, 1));
        for (k = 0; k < FIELD_SAMPLES; k++) begin
          v = cluster ? center + $urandom_range(0, 64) - 32 : $urandom_range(0, 4095);
          if (v < 0) v = 0;
          if (v > 4095) v = 4095;
          q.smp[k] = v[SMP_W-1:0];
        end
        send_query(q);
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.failures == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
